// File: design/pbt_pkg.sv
// Package: shared types, constants and codes for the polygon backface test.
`default_nettype none

package pbt_pkg;

    localparam int COORD_BITS       = 24;
    localparam int LIMB_BITS        = 32;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int JOB_QUEUE_DEPTH  = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   opnd_t;

    typedef struct packed {
        coord_t vx;
        coord_t vy;
        coord_t vz;
        logic   closes_polygon;
    } vertex_t;

    typedef struct packed {
        logic facing;
        logic overflow;
    } result_t;

    typedef enum logic [1:0] {
        JOB_EDGE,
        JOB_CLOSE,
        JOB_OVER
    } job_op_t;

    // One edge term set (differences and sums per normal component) plus
    // the first vertex, needed by the back end for the final dot product.
    typedef struct packed {
        job_op_t       op;
        opnd_t [2:0]   dif;
        opnd_t [2:0]   sum;
        coord_t [2:0]  first;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_EDGE,
        F_END
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ACC,
        B_DMUL,
        B_DACC,
        B_RESULT
    } back_state_t;

endpackage

`default_nettype wire

// File: design/pbt_front.sv
// Front end: takes vertices, tracks first/prior vertex and count, issues edge, closing and overflow jobs.
`default_nettype none

module pbt_front
    import pbt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire vertex_t vertex,
    output job_t         job,
    output logic         job_push,
    input  wire logic    job_full
);

    localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);

    front_state_t        state_reg, state_next;
    vertex_t             vtx_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                too_many_reg, too_many_next;
    coord_t [2:0]        first_reg, first_next;
    coord_t [2:0]        prior_reg, prior_next;
    coord_t [2:0]        cur;
    logic                excess;
    logic                need_edge;

    // Newell terms for the edge from pj to pi: x uses y/z, y uses z/x, z uses x/y
    function automatic job_t edge_job(input coord_t [2:0] pj, input coord_t [2:0] pi);
        job_t j;
        j        = '0;
        j.op     = JOB_EDGE;
        j.dif[0] = opnd_t'($signed(pj[1])) - opnd_t'($signed(pi[1]));
        j.sum[0] = opnd_t'($signed(pj[2])) + opnd_t'($signed(pi[2]));
        j.dif[1] = opnd_t'($signed(pj[2])) - opnd_t'($signed(pi[2]));
        j.sum[1] = opnd_t'($signed(pj[0])) + opnd_t'($signed(pi[0]));
        j.dif[2] = opnd_t'($signed(pj[0])) - opnd_t'($signed(pi[0]));
        j.sum[2] = opnd_t'($signed(pj[1])) + opnd_t'($signed(pi[1]));
        return j;
    endfunction

    assign cur[0]    = vtx_reg.vx;
    assign cur[1]    = vtx_reg.vy;
    assign cur[2]    = vtx_reg.vz;
    assign excess    = (count_reg == CNT_BITS'(MAX_VERTICES));
    assign need_edge = !excess && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            count_reg    <= '0;
            too_many_reg <= 1'b0;
            first_reg    <= '0;
            prior_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            too_many_reg <= too_many_next;
            first_reg    <= first_next;
            prior_reg    <= prior_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            vtx_reg <= vertex;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        too_many_next = too_many_reg;
        first_next    = first_reg;
        prior_next    = prior_reg;
        full          = 1'b1;
        job_push      = 1'b0;
        job           = edge_job(prior_reg, cur);

        unique case (state_reg)
            F_IDLE:
            begin
                full = 1'b0;
                if (push)
                begin
                    state_next = F_EDGE;
                end
            end
            F_EDGE:
            begin
                if (!need_edge || !job_full)
                begin
                    job_push = need_edge;
                    if (excess)
                    begin
                        too_many_next = 1'b1;
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            first_next = cur;
                        end
                        prior_next = cur;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = vtx_reg.closes_polygon ? F_END : F_IDLE;
                end
            end
            F_END:
            begin
                // closing edge back to the first vertex, or an overflow marker
                job       = edge_job(prior_reg, first_reg);
                job.first = first_reg;
                job.op    = too_many_reg ? JOB_OVER : JOB_CLOSE;
                if (!job_full)
                begin
                    job_push      = 1'b1;
                    count_next    = '0;
                    too_many_next = 1'b0;
                    state_next    = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/pbt_queue.sv
// Short job queue between the front and back ends.
`default_nettype none

module pbt_queue
    import pbt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire job_t din,
    output logic      full,
    input  wire logic rd,
    output job_t      dout,
    output logic      empty
);

    localparam int PTR_BITS = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(JOB_QUEUE_DEPTH + 1);

    job_t                slot_reg [JOB_QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr;
    logic                do_rd;

    assign full  = (count_reg == CNT_BITS'(JOB_QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(JOB_QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(JOB_QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// File: design/pbt_back.sv
// Back end: Newell accumulation, limb-serial dot product and result register.
`default_nettype none

module pbt_back
    import pbt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t job,
    input  wire logic job_empty,
    output logic      job_pop,
    output result_t   result,
    output logic      empty,
    input  wire logic pop
);

    localparam int PROD_BITS = 2 * COORD_BITS + 2;
    localparam int NORM_BITS = PROD_BITS + 1 + $clog2(MAX_VERTICES);
    localparam int NLIMB     = (NORM_BITS + LIMB_BITS - 1) / LIMB_BITS;
    localparam int IDX_BITS  = (NLIMB > 1) ? $clog2(NLIMB) : 1;
    localparam int EXT_BITS  = NLIMB * LIMB_BITS;
    localparam int PART_BITS = LIMB_BITS + 1 + COORD_BITS;
    localparam int DOT_BITS  = EXT_BITS + COORD_BITS + 3;

    back_state_t                state_reg, state_next;
    job_op_t                    op_reg, op_next;
    coord_t [2:0]               first_reg, first_next;
    logic signed [PROD_BITS-1:0] prod_reg [3];
    logic signed [PROD_BITS-1:0] prod_next [3];
    logic signed [NORM_BITS-1:0] norm_reg [3];
    logic signed [NORM_BITS-1:0] norm_next [3];
    logic signed [PART_BITS-1:0] part_reg [3];
    logic signed [PART_BITS-1:0] part_next [3];
    logic [EXT_BITS-1:0]        norm_ext [3];
    logic [LIMB_BITS-1:0]       limb [3];
    logic signed [LIMB_BITS:0]  limb_op [3];
    logic [IDX_BITS-1:0]        idx_reg, idx_next;
    logic signed [DOT_BITS-1:0] dot_reg, dot_next;
    logic                       ovf_reg, ovf_next;
    logic                       top_limb;
    logic                       out_valid_reg, out_valid_next;
    result_t                    out_reg, out_next;
    logic                       out_load;
    logic                       out_free;

    assign out_free = !out_valid_reg || pop;
    assign top_limb = (idx_reg == IDX_BITS'(NLIMB - 1));
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // top limb of the normal is signed, lower limbs are plain magnitudes
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            norm_ext[k] = EXT_BITS'(norm_reg[k]);
            limb[k]     = norm_ext[k][idx_reg*LIMB_BITS +: LIMB_BITS];
            limb_op[k]  = $signed({top_limb & limb[k][LIMB_BITS-1], limb[k]});
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        first_next = first_reg;
        idx_next   = idx_reg;
        dot_next   = dot_reg;
        ovf_next   = ovf_reg;
        job_pop    = 1'b0;
        out_load   = 1'b0;
        out_next   = out_reg;
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k] = prod_reg[k];
            norm_next[k] = norm_reg[k];
            part_next[k] = part_reg[k];
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop = 1'b1;
                    if (job.op == JOB_OVER)
                    begin
                        ovf_next   = 1'b1;
                        state_next = B_RESULT;
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            prod_next[k] = $signed(job.dif[k]) * $signed(job.sum[k]);
                        end
                        op_next    = job.op;
                        first_next = job.first;
                        state_next = B_ACC;
                    end
                end
            end
            B_ACC:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    norm_next[k] = norm_reg[k] + NORM_BITS'(prod_reg[k]);
                end
                if (op_reg == JOB_CLOSE)
                begin
                    idx_next   = IDX_BITS'(NLIMB - 1);
                    dot_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = B_DMUL;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_DMUL:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    part_next[k] = limb_op[k] * $signed(first_reg[k]);
                end
                state_next = B_DACC;
            end
            B_DACC:
            begin
                // Horner over limbs, most significant first
                dot_next = (dot_reg <<< LIMB_BITS) + DOT_BITS'(part_reg[0])
                         + DOT_BITS'(part_reg[1]) + DOT_BITS'(part_reg[2]);
                if (idx_reg == '0)
                begin
                    state_next = B_RESULT;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = B_DMUL;
                end
            end
            B_RESULT:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_next.facing   = !ovf_reg && !dot_reg[DOT_BITS-1] && (dot_reg != '0);
                    out_next.overflow = ovf_reg;
                    for (int k = 0; k < 3; k++)
                    begin
                        norm_next[k] = '0;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            for (int k = 0; k < 3; k++)
            begin
                norm_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            for (int k = 0; k < 3; k++)
            begin
                norm_reg[k] <= norm_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        first_reg <= first_next;
        dot_reg   <= dot_next;
        out_reg   <= out_next;
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= prod_next[k];
            part_reg[k] <= part_next[k];
        end
    end

endmodule

`default_nettype wire

// File: design/polygon_backface_test_top.sv
// Top level: polygon backface test by Newell normal, queue-style channels.
//
// Usage:
//   Input channel: drive a vertex (vx, vy, vz in signed Q12.12, closes_polygon
//   on the last vertex) with push; a transfer happens on a clock edge with
//   push high and full low. Result channel: while empty is low, result holds
//   the oldest waiting result (facing, overflow); a transfer happens on an
//   edge with pop high and empty low. One result per closed polygon.
//   The front end takes a vertex, then issues its edge job, and takes no
//   new vertex until it has done so; the back end multiplies, then
//   accumulates, per edge; the closing vertex also passes through the
//   front end's end state. A result comes out of the limb-serial dot
//   product in the back end, a multiply and an accumulate step for each
//   32-bit limb of the normal, most significant first (2 limbs at defaults).
//   Polygons over MAX_VERTICES vertices give facing = 0, overflow = 1.
//   Reset (rst_n low, asynchronous) empties the job queue and result
//   register and clears all polygon state; no clearing pass is needed.
//   A stalled receiver holds one result in the output register; the front
//   end keeps taking vertices until the job queue fills.
`default_nettype none

module polygon_backface_test_top
    import pbt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire vertex_t vertex,
    output logic         empty,
    input  wire logic    pop,
    output result_t      result
);

    job_t job_in;
    job_t job_out;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;

    // front: vertex bookkeeping and edge operand formation
    pbt_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .vertex   (vertex),
        .job      (job_in),
        .job_push (job_push),
        .job_full (job_full)
    );

    // decouples front and back so each can stall on its own
    pbt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_push),
        .din   (job_in),
        .full  (job_full),
        .rd    (job_pop),
        .dout  (job_out),
        .empty (job_empty)
    );

    // back: normal accumulation, dot product, result register
    pbt_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

// File: tb/sv/polygon_backface_test_top_tb.sv
// Testbench for polygon_backface_test_top: Newell-normal facing verdicts vs. a local predictor.
`timescale 1ns / 100ps

module polygon_backface_test_top_tb;
    import pbt_pkg::*;

    localparam int MAX_VERTS     = MAX_VERTICES_DEF;
    localparam int RANDOM_ITEMS  = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;   // watch time after the last awaited verdict

    // Q12.12 landmarks
    localparam coord_t C_MAX  = 24'sh7FFFFF;
    localparam coord_t C_MIN  = 24'sh800000;
    localparam coord_t C_ONE  = 24'sh001000;
    localparam coord_t C_TWO  = 24'sh002000;
    localparam coord_t C_THR  = 24'sh003000;
    localparam coord_t C_MONE = -24'sh001000;

    // Coordinate styles for random vertices.
    typedef enum int {
        CS_WIDE,      // any 24-bit pattern
        CS_NEAR,      // within +/- 8.0, so sign of the verdict varies a lot
        CS_EXTREME    // range ends, zero, +/- one lsb, +/- 1.0
    } coord_style_t;

    // Polygon shapes for the random part.
    typedef enum int {
        SH_NEAR,
        SH_WIDE,
        SH_EXTREME,
        SH_MIXED,       // each coordinate picks its own style
        SH_COLLINEAR    // all vertices on a line through the origin: zero normal
    } shape_t;

    typedef coord_t vec3_t [3];

    // One row of the directed stimulus. Rows with known_verdict set carry the
    // verdict typed in; all others take the predictor's.
    typedef struct packed {
        vertex_t v;
        logic    known_verdict;
        result_t verdict;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    vertex_t vertex;
    logic    empty;
    logic    pop;
    result_t result;

    polygon_backface_test_top #(
        .MAX_VERTICES(MAX_VERTS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .vertex (vertex),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // ------------------------------------------------------------------
    // Predictor state: one open polygon, exact Newell sums.
    // ------------------------------------------------------------------
    vec3_t               first_v;
    vec3_t               prior_v;
    logic signed [127:0] norm_x;
    logic signed [127:0] norm_y;
    logic signed [127:0] norm_z;
    int unsigned         vert_count;
    bit                  too_many_seen;

    // Verdicts owed by the block, oldest first.
    result_t awaited_verdicts[$];

    int unsigned fail_count;
    int unsigned verdicts_checked;
    int unsigned facing_seen;
    int unsigned overflow_seen;
    int unsigned vertex_transfers;
    int unsigned full_stalls;

    bit   calm;       // no idling on either side while set
    bit   holding;    // receiver holds off completely while set
    event hold_off_start;

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d verdicts still awaited", awaited_verdicts.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_polygon();
        for (int k = 0; k < 3; k++)
        begin
            first_v[k] = '0;
            prior_v[k] = '0;
        end
        norm_x        = '0;
        norm_y        = '0;
        norm_z        = '0;
        vert_count    = 0;
        too_many_seen = 1'b0;
    endfunction

    // (dj - di) * (sj + si), exact
    function automatic logic signed [127:0] cross_term(input coord_t dj, input coord_t di,
                                                       input coord_t sj, input coord_t si);
        logic signed [127:0] dif;
        logic signed [127:0] sum;
        dif = dj;
        dif = dif - di;
        sum = sj;
        sum = sum + si;
        return dif * sum;
    endfunction

    // Newell contribution of the edge from pj to pi
    function automatic void add_newell_edge(input vec3_t pj, input vec3_t pi);
        norm_x += cross_term(pj[1], pi[1], pj[2], pi[2]);
        norm_y += cross_term(pj[2], pi[2], pj[0], pi[0]);
        norm_z += cross_term(pj[0], pi[0], pj[1], pi[1]);
    endfunction

    // Takes one accepted vertex; on the closing vertex returns the verdict.
    function automatic void newell_step(input vertex_t v, output bit closed,
                                        output result_t verdict);
        vec3_t               cur;
        logic signed [127:0] dot;
        cur[0]  = v.vx;
        cur[1]  = v.vy;
        cur[2]  = v.vz;
        closed  = v.closes_polygon;
        verdict = '0;
        // Excess vertices only mark the polygon; they add no edge.
        if (vert_count >= MAX_VERTS)
            too_many_seen = 1'b1;
        else
        begin
            if (vert_count == 0)
                first_v = cur;
            else
                add_newell_edge(prior_v, cur);
            prior_v = cur;
            vert_count++;
        end
        if (closed)
        begin
            if (too_many_seen)
                verdict.overflow = 1'b1;
            else
            begin
                add_newell_edge(prior_v, first_v);
                dot = norm_x * first_v[0] + norm_y * first_v[1] + norm_z * first_v[2];
                verdict.facing = (dot > 0);
            end
            clear_polygon();
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Entered and left at a falling edge; push stays high
    // between back-to-back transfers so it is never lowered and raised
    // in the same step.
    // ------------------------------------------------------------------
    task automatic send_vertex(input vertex_t v, input bit known, input result_t typed);
        bit      closed;
        result_t verdict;
        while (!calm && $urandom_range(99) < 30)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push   <= 1'b1;
        vertex <= v;
        do
            @(posedge clk);
        while (full);
        newell_step(v, closed, verdict);
        vertex_transfers++;
        if (closed)
            awaited_verdicts.push_back(known ? typed : verdict);
        @(negedge clk);
    endtask

    function automatic coord_t pick_coord(input coord_style_t style);
        case (style)
            CS_WIDE:
                return coord_t'($urandom);
            CS_NEAR:
                return coord_t'(int'($urandom_range(65535)) - 32768);
            default:
                case ($urandom_range(6))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return '0;
                    3:       return coord_t'(1);
                    4:       return coord_t'(-1);
                    5:       return C_ONE;
                    default: return C_MONE;
                endcase
        endcase
    endfunction

    function automatic coord_style_t any_style();
        return coord_style_t'($urandom_range(2));
    endfunction

    task automatic send_polygon(input int unsigned n, input shape_t shape);
        vertex_t      v;
        coord_style_t style;
        coord_t       bx;
        coord_t       by;
        coord_t       bz;
        bx = pick_coord(CS_NEAR);
        by = pick_coord(CS_NEAR);
        bz = pick_coord(CS_NEAR);
        style = (shape == SH_WIDE) ? CS_WIDE : (shape == SH_EXTREME) ? CS_EXTREME : CS_NEAR;
        for (int unsigned k = 0; k < n; k++)
        begin
            case (shape)
                SH_COLLINEAR:
                begin
                    v.vx = bx * coord_t'(k + 1);
                    v.vy = by * coord_t'(k + 1);
                    v.vz = bz * coord_t'(k + 1);
                end
                SH_MIXED:
                begin
                    v.vx = pick_coord(any_style());
                    v.vy = pick_coord(any_style());
                    v.vz = pick_coord(any_style());
                end
                default:
                begin
                    v.vx = pick_coord(style);
                    v.vy = pick_coord(style);
                    v.vz = pick_coord(style);
                end
            endcase
            v.closes_polygon = (k == n - 1);
            send_vertex(v, 1'b0, '0);
        end
    endtask

    function automatic stim_row_t mk_row(input coord_t x, input coord_t y, input coord_t z,
                                         input logic last, input logic known,
                                         input logic fac, input logic ovf);
        stim_row_t r;
        r.v.vx             = x;
        r.v.vy             = y;
        r.v.vz             = z;
        r.v.closes_polygon = last;
        r.known_verdict    = known;
        r.verdict.facing   = fac;
        r.verdict.overflow = ovf;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random pops, a long hold-off on request, no idling
    // while calm is set.
    // ------------------------------------------------------------------
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= !holding && (calm || $urandom_range(99) >= 30);
        end
    end

    // Hold-off counted here so the sender keeps offering vertices and the
    // block backs up to full.
    initial
    begin
        holding = 1'b0;
        @(hold_off_start);
        @(posedge clk);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    // ------------------------------------------------------------------
    // Result check: every transfer against the oldest awaited verdict.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (push && full)
                full_stalls++;
            if (pop && !empty)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result facing=%0b overflow=%0b",
                                 $realtime, result.facing, result.overflow);
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    verdicts_checked++;
                    if (result.facing)
                        facing_seen++;
                    if (result.overflow)
                        overflow_seen++;
                    if (result.facing !== want.facing || result.overflow !== want.overflow)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: verdict %0d: facing exp %0b got %0b, overflow exp %0b got %0b",
                                     $realtime, verdicts_checked, want.facing, result.facing,
                                     want.overflow, result.overflow);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t   stim_rows[$];
        int unsigned random_sent;
        int unsigned sides;
        int unsigned pick;
        shape_t      shape;
        bit          hold_fired;

        rst_n            = 1'b0;
        push             = 1'b0;
        vertex           = '0;
        calm             = 1'b0;
        fail_count       = 0;
        verdicts_checked = 0;
        facing_seen      = 0;
        overflow_seen    = 0;
        vertex_transfers = 0;
        full_stalls      = 0;
        random_sent      = 0;
        hold_fired       = 1'b0;
        clear_polygon();

        // Directed part: degenerate polygons have an obvious verdict, the
        // rest go through the predictor.
        // single vertex, all zero / extremes: no normal
        stim_rows.push_back(mk_row('0, '0, '0, 1'b1, 1'b1, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_MAX, C_MIN, C_MAX, 1'b1, 1'b1, 1'b0, 1'b0));
        // two vertices at opposite corners: edge and its reverse cancel
        stim_rows.push_back(mk_row(C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, 1'b0, 1'b0));
        // three copies of one vertex: zero area
        stim_rows.push_back(mk_row(C_MAX, C_MIN, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_MAX, C_MIN, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_MAX, C_MIN, C_MAX, 1'b1, 1'b1, 1'b0, 1'b0));
        // unit triangle at z = 1.0, one winding then the other
        stim_rows.push_back(mk_row('0, '0, C_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_ONE, '0, C_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row('0, C_ONE, C_ONE, 1'b1, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row('0, C_ONE, C_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_ONE, '0, C_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row('0, '0, C_ONE, 1'b1, 1'b0, 1'b0, 1'b0));
        // full-range quad: largest sums and products
        stim_rows.push_back(mk_row(C_MIN, C_MIN, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_MAX, C_MIN, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_MIN, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, 1'b0));
        // mixed-sign extreme triangle
        stim_rows.push_back(mk_row(C_MIN, C_MAX, C_MIN, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_MAX, C_MIN, C_MIN, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, 1'b0));
        // collinear through the origin: zero normal
        stim_rows.push_back(mk_row(C_ONE, C_ONE, C_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_TWO, C_TWO, C_TWO, 1'b0, 1'b0, 1'b0, 1'b0));
        stim_rows.push_back(mk_row(C_THR, C_THR, C_THR, 1'b1, 1'b1, 1'b0, 1'b0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_rows[i])
            send_vertex(stim_rows[i].v, stim_rows[i].known_verdict, stim_rows[i].verdict);

        // Length limits: exactly the maximum, sent with no idling on either
        // side, then a polygon whose last three vertices are excess, the
        // closing one among them.
        calm <= 1'b1;
        send_polygon(MAX_VERTS, SH_WIDE);
        calm <= 1'b0;
        send_polygon(MAX_VERTS + 3, SH_NEAR);

        // Random polygons, mostly 3..10 vertices, some 1 or 2.
        while (random_sent < RANDOM_ITEMS)
        begin
            if (!hold_fired && random_sent >= 40)
            begin
                -> hold_off_start;
                hold_fired = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 8)
                sides = 1;
            else if (pick < 16)
                sides = 2;
            else if (pick < 60)
                sides = 3;
            else
                sides = $urandom_range(10, 4);
            pick = $urandom_range(99);
            if (pick < 45)
                shape = SH_NEAR;
            else if (pick < 65)
                shape = SH_WIDE;
            else if (pick < 80)
                shape = SH_EXTREME;
            else if (pick < 90)
                shape = SH_MIXED;
            else
                shape = SH_COLLINEAR;
            send_polygon(sides, shape);
            random_sent += sides;
        end
        push <= 1'b0;

        // Drain, then watch a while for anything extra.
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d vertex transfers and %0d verdicts (%0d facing, %0d overflow).",
                 vertex_transfers, verdicts_checked, facing_seen, overflow_seen);
        $display("Input held off by full for %0d cycles in total; %0d failures.",
                 full_stalls, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
